[src/hla_pkg.sv]
// Package for the Huber loss accumulator: queue item type, status codes and
// fixed-point constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hla_pkg;

    // Q16.16 one, used as the weight when weighting is off
    localparam logic [31:0] Q_ONE      = 32'h0001_0000;
    localparam logic [31:0] DELTA_RST  = 32'h0001_0000;
    localparam logic [62:0] MEAN_MAX   = {63{1'b1}};

    // divider works on {loss_sum, 16 zero bits}, one quotient bit per cycle
    localparam int          DIV_BITS   = 80;

    // result status codes
    localparam logic [1:0]  STATUS_OK        = 2'd0;
    localparam logic [1:0]  STATUS_ZERO_WSUM = 2'd1;
    localparam logic [1:0]  STATUS_SAT       = 2'd2;

    // register indexes on the configuration port
    localparam logic        REG_DELTA       = 1'b0;
    localparam logic        REG_USE_WEIGHTS = 1'b1;

    // one classified beat between front and back
    typedef struct packed {
        logic [63:0] wterm;     // weighted term, already saturated
        logic        wsat;      // weighting step saturated
        logic [31:0] weight;    // effective weight
        logic        last;
    } t_q_item;

endpackage

`default_nettype wire

[src/hla_fifo.sv]
// Short register queue between front and back of the Huber loss accumulator.
// Depends on hla_pkg. Overflow is prevented by the front's credit count.
`timescale 1ns / 1ps
`default_nettype none

module hla_fifo #(
    parameter int DEPTH = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  hla_pkg::t_q_item    i_data,
    input  wire                 i_pop,
    output hla_pkg::t_q_item    o_data,
    output logic                o_empty
);
    import hla_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_q_item         r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);

endmodule

`default_nettype wire

[src/hla_front.sv]
// Front end of the Huber loss accumulator: accepts samples, forms the Huber
// term and weights it in a five-stage pipeline. Depends on hla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hla_front #(
    parameter int DEPTH = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire signed [31:0]   i_actual_value,
    input  wire signed [31:0]   i_predicted_value,
    input  wire [31:0]          i_weight,
    input  wire                 i_last,
    input  wire [31:0]          i_delta,
    input  wire                 i_use_weights,
    input  wire                 i_pop,
    output logic                o_push,
    output hla_pkg::t_q_item    o_item
);
    import hla_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic                 accept;
    logic [CW-1:0]        r_occ, n_occ;
    logic [5:1]           r_vld;

    // stage 1: difference
    logic signed [32:0]   r_d;
    logic [31:0]          r_w1;
    logic                 r_l1;
    // stage 2: magnitude, region, linear operand
    logic [32:0]          r_absd;
    logic                 r_le;
    logic [33:0]          r_x;
    logic [31:0]          r_w2;
    logic                 r_l2;
    // stage 3: products
    logic [63:0]          r_prod;
    logic [33:0]          r_hi;
    logic [31:0]          r_w3;
    logic                 r_l3;
    // stage 4: term
    logic [48:0]          r_term;
    logic [31:0]          r_w4;
    logic                 r_l4;
    // stage 5: weighted halves
    logic [48:0]          r_mhi;
    logic [63:0]          r_mlo;
    logic [31:0]          r_w5;
    logic                 r_l5;

    logic [32:0]          absd;
    logic [31:0]          op_a, op_b;
    logic [33:0]          hi_sel;
    logic [64:0]          wsum;

    // credit count covers items in the pipeline and in the queue
    assign o_stall = (r_occ == CW'(DEPTH));
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_occ = r_occ;
        if (accept && !i_pop) begin
            n_occ = r_occ + 1'b1;
        end else if (!accept && i_pop) begin
            n_occ = r_occ - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
            r_vld <= '0;
        end else begin
            r_occ <= n_occ;
            r_vld <= {r_vld[4:1], accept};
        end
    end

    always_comb begin
        absd = r_d[32] ? 33'(-r_d) : 33'(r_d);
        op_a = r_le ? r_absd[31:0] : i_delta;
        op_b = r_le ? r_absd[31:0] : r_x[31:0];
        case (r_x[33:32])
            2'd1:    hi_sel = {2'b00, i_delta};
            2'd2:    hi_sel = {1'b0, i_delta, 1'b0};
            default: hi_sel = '0;
        endcase
        wsum = {1'b0, r_mhi[47:0], 16'b0} + {17'b0, r_mlo[63:16]};
    end

    always_ff @(posedge i_clk) begin
        r_d    <= {i_actual_value[31], i_actual_value}
                - {i_predicted_value[31], i_predicted_value};
        r_w1   <= i_use_weights ? i_weight : Q_ONE;
        r_l1   <= i_last;

        r_absd <= absd;
        r_le   <= (absd <= {1'b0, i_delta});
        r_x    <= {absd, 1'b0} - {2'b00, i_delta};
        r_w2   <= r_w1;
        r_l2   <= r_l1;

        r_prod <= {32'b0, op_a} * {32'b0, op_b};
        r_hi   <= r_le ? '0 : hi_sel;
        r_w3   <= r_w2;
        r_l3   <= r_l2;

        r_term <= {r_hi, 15'b0} + {2'b00, r_prod[63:17]};
        r_w4   <= r_w3;
        r_l4   <= r_l3;

        r_mhi  <= {32'b0, r_term[48:32]} * {17'b0, r_w4};
        r_mlo  <= {32'b0, r_term[31:0]} * {32'b0, r_w4};
        r_w5   <= r_w4;
        r_l5   <= r_l4;
    end

    always_comb begin
        o_push       = r_vld[5];
        o_item.wterm = wsum[64] ? {64{1'b1}} : wsum[63:0];
        o_item.wsat  = wsum[64];
        o_item.weight = r_w5;
        o_item.last  = r_l5;
    end

endmodule

`default_nettype wire

[src/hla_back.sv]
// Back end of the Huber loss accumulator: saturating sums, bit-serial Q16.16
// divider and the output register. Depends on hla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hla_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  hla_pkg::t_q_item    i_item,
    input  wire                 i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_stall,
    output logic [62:0]         o_mean_loss,
    output logic [1:0]          o_status
);
    import hla_pkg::*;

    localparam int NW = $clog2(DIV_BITS);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } t_back_state;

    t_back_state              r_state, n_state;
    logic [63:0]              r_loss, r_wsum;
    logic                     r_ovf;
    logic [DIV_BITS-1:0]      r_dq;
    logic [63:0]              r_rem, r_den;
    logic                     r_dovf, r_zero;
    logic [NW-1:0]            r_cnt;
    logic                     r_out_valid;
    logic [62:0]              r_mean;
    logic [1:0]               r_status;

    logic [64:0]              lsum, wsum;
    logic [63:0]              loss_nx, wsum_nx;
    logic                     ovf_nx;
    logic [64:0]              trial, diff;
    logic                     qbit, out_free, qsat;

    always_comb begin
        lsum    = {1'b0, r_loss} + {1'b0, i_item.wterm};
        wsum    = {1'b0, r_wsum} + {33'b0, i_item.weight};
        loss_nx = lsum[64] ? {64{1'b1}} : lsum[63:0];
        wsum_nx = wsum[64] ? {64{1'b1}} : wsum[63:0];
        ovf_nx  = r_ovf || i_item.wsat || lsum[64] || wsum[64];

        // a last beat waits until the divider is free
        o_pop   = !i_empty && (!i_item.last || r_state == ST_IDLE);

        trial   = {r_rem, r_dq[DIV_BITS-1]};
        diff    = trial - {1'b0, r_den};
        qbit    = !diff[64];

        out_free = !r_out_valid || !i_stall;
        qsat     = |r_dq[DIV_BITS-1:63];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_pop && i_item.last) begin
                    n_state = (wsum_nx == '0) ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == NW'(DIV_BITS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_loss      <= '0;
            r_wsum      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                if (i_item.last) begin
                    r_loss <= '0;
                    r_wsum <= '0;
                    r_ovf  <= 1'b0;
                end else begin
                    r_loss <= loss_nx;
                    r_wsum <= wsum_nx;
                    r_ovf  <= ovf_nx;
                end
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && o_pop && i_item.last) begin
            r_dq   <= {loss_nx, 16'b0};
            r_rem  <= '0;
            r_den  <= wsum_nx;
            r_dovf <= ovf_nx;
            r_zero <= (wsum_nx == '0);
            r_cnt  <= '0;
        end else if (r_state == ST_DIV) begin
            r_dq   <= {r_dq[DIV_BITS-2:0], qbit};
            r_rem  <= qbit ? diff[63:0] : trial[63:0];
            r_cnt  <= r_cnt + 1'b1;
        end
        if (r_state == ST_DONE && out_free) begin
            if (r_zero) begin
                r_mean   <= '0;
                r_status <= STATUS_ZERO_WSUM;
            end else begin
                r_mean   <= qsat ? MEAN_MAX : r_dq[62:0];
                r_status <= (qsat || r_dovf) ? STATUS_SAT : STATUS_OK;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_mean_loss = r_mean;
    assign o_status    = r_status;

endmodule

`default_nettype wire

[src/huber_loss_accumulator.sv]
// Top level of the Huber loss accumulator: configuration registers and the
// front, queue and back instances. Depends on hla_pkg, hla_front, hla_fifo, hla_back.
//
// Usage
//   Input channel (i_valid / o_stall): one sample beat per cycle, carrying the
//   observed and predicted Q16.16 values, a Q16.16 weight and a last flag.
//   Output channel (o_valid / i_stall): one result beat per vector, the mean
//   loss (Q16.16, saturated) and a status (ok, zero weight sum, saturated).
//   APB port: register 0 at 0x0 is delta, register 1 at 0x4 is use_weights;
//   write only while the block is idle.
// Timing
//   Samples that are not last are taken one per cycle while o_stall is low;
//   each passes through the front pipeline, the queue and the back. A last
//   beat starts a bit-serial divide (one quotient bit per cycle) before its
//   result is offered; when the weight sum is zero the divide is skipped.
//   Samples of the next vector keep flowing meanwhile until another last beat
//   reaches the back.
// Reset: synchronous, active low; sums and flags clear, delta = 1.0, weighting off.
// Back-pressure: a stalled result holds in the output register; the divider then
// waits, a last beat stays queued, and o_stall rises at QUEUE_DEPTH beats in flight.
`timescale 1ns / 1ps
`default_nettype none

module huber_loss_accumulator #(
    parameter int QUEUE_DEPTH = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // sample channel
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire signed [31:0]   i_actual_value,
    input  wire signed [31:0]   i_predicted_value,
    input  wire [31:0]          i_weight,
    input  wire                 i_last,
    // result channel
    output logic                o_valid,
    input  wire                 i_stall,
    output logic [62:0]         o_mean_loss,
    output logic [1:0]          o_status,
    // configuration
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire [2:0]           paddr,
    input  wire [31:0]          pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import hla_pkg::*;

    logic [31:0]  r_delta;
    logic         r_use_weights;
    logic         cfg_wr;

    logic         push, pop, empty;
    t_q_item      push_item, head_item;

    // register select is paddr[2]; low address bits are ignored
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta       <= DELTA_RST;
            r_use_weights <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_DELTA:       r_delta       <= pwdata;
                REG_USE_WEIGHTS: r_use_weights <= pwdata[0];
                default:         r_delta       <= r_delta;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_DELTA:       prdata = r_delta;
            REG_USE_WEIGHTS: prdata = {31'b0, r_use_weights};
            default:         prdata = '0;
        endcase
    end

    // front: difference, Huber term, weighting
    hla_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_actual_value    (i_actual_value),
        .i_predicted_value (i_predicted_value),
        .i_weight          (i_weight),
        .i_last            (i_last),
        .i_delta           (r_delta),
        .i_use_weights     (r_use_weights),
        .i_pop             (pop),
        .o_push            (push),
        .o_item            (push_item)
    );

    // queue decouples the pipeline from the accumulator and divider
    hla_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .i_pop   (pop),
        .o_data  (head_item),
        .o_empty (empty)
    );

    // back: saturating sums, divide, result register
    hla_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (head_item),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_mean_loss (o_mean_loss),
        .o_status    (o_status)
    );

endmodule

`default_nettype wire
